// ===== rtl/yce_pkg.sv =====
// Shared types and constants of the yaw complementary estimator.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package yce_pkg;

    localparam int ANGLE_BITS     = 16;
    localparam int RATE_FRAC_BITS = 9;
    localparam int RATE_W         = 16;
    localparam int FUSED_W        = ANGLE_BITS + 8;
    localparam int DT_W           = 19;
    localparam int TAU_W          = 20;
    localparam int GAIN_W         = 17;
    localparam int ALPHA_W        = 17;
    localparam int DEN_W          = 21;
    localparam int NUM_W          = 36;
    localparam int DIV_STEPS      = NUM_W;
    localparam int CNT_W          = 6;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 20;
    localparam int MUL_A_W        = 40;
    localparam int MUL_B_W        = 20;
    localparam int PROD_W         = MUL_A_W + MUL_B_W;
    localparam int P_W            = 38;
    localparam int INT_SHIFT      = 49 + RATE_FRAC_BITS - ANGLE_BITS;

    localparam logic [19:0] DT_DEFAULT_US = 20'd10000;
    localparam logic [19:0] DT_MAX_US     = 20'd500000;
    localparam logic [19:0] INV_PI_MEGA   = 20'd349985;
    localparam logic [16:0] GAIN_ONE      = 17'd65536;
    localparam logic [19:0] TAU_RESET     = 20'd25000;
    localparam logic [16:0] GAIN_RESET    = 17'd6554;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_YAW_NEGATE = 2'd0,
        REG_TAU        = 2'd1,
        REG_GAIN       = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic              action;
        logic              orient_valid;
        logic signed [15:0] yaw_in;
        logic signed [15:0] roll_in;
        logic signed [15:0] pitch_in;
        logic              gyro_valid;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic [19:0]       step_time_us;
    } item_t;

    typedef struct packed {
        logic signed [15:0] yaw_estimate;
        logic signed [15:0] yaw_sensor;
        logic signed [15:0] roll_out;
        logic signed [15:0] pitch_out;
        logic signed [15:0] filtered_rate_x;
        logic signed [15:0] filtered_rate_y;
        logic signed [15:0] filtered_rate_z;
        logic              offset_latched;
        logic              has_orientation;
        logic              has_rate;
    } result_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_STEP,
        OP_ALPHA,
        OP_FMUL,
        OP_FACC,
        OP_PMUL,
        OP_HIMUL,
        OP_LOMUL,
        OP_INTADD,
        OP_CMUL,
        OP_CADD,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic zeroed;
        logic has_orient;
    } dp_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_ALPHA,
        S_FMUL,
        S_FACC,
        S_PMUL,
        S_HIMUL,
        S_LOMUL,
        S_INTADD,
        S_CMUL,
        S_CADD,
        S_EMIT
    } ctrl_state_t;

endpackage

// ===== rtl/yce_item_if.sv =====
// Request channel carrying one input item.
// Depends on yce_pkg.
`timescale 1ns / 1ps

interface yce_item_if;
    import yce_pkg::*;
    logic  valid;
    logic  ready;
    item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/yce_result_if.sv =====
// Request channel carrying one result item.
// Depends on yce_pkg.
`timescale 1ns / 1ps

interface yce_result_if;
    import yce_pkg::*;
    logic    valid;
    logic    ready;
    result_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/yce_datapath.sv =====
// Datapath: configuration, filter state, divider, shared multiplier, output register.
// Depends on yce_pkg; sequenced by yce_ctrl.
`timescale 1ns / 1ps

module yce_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  yce_pkg::dp_cmd_t            cmd,
    output yce_pkg::dp_status_t         status,
    input  yce_pkg::item_t              item,
    output yce_pkg::result_t            result,
    input  logic                        cfg_write_en,
    input  logic [yce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [yce_pkg::CFG_DATA_W-1:0] cfg_data
);
    import yce_pkg::*;

    logic                      negate_reg;
    logic [TAU_W-1:0]          tau_reg;
    logic [GAIN_W-1:0]         gain_reg;

    logic                      zero_pending_reg, zeroed_reg, has_orient_reg, has_rate_reg;
    logic [ANGLE_BITS-1:0]     offset_reg, sensor_reg, roll_reg, pitch_reg;
    logic [FUSED_W-1:0]        fused_reg;
    logic signed [RATE_W-1:0]  raw_reg [3];
    logic signed [31:0]        filt_reg [3];

    logic [DT_W-1:0]           dt_reg;
    logic [NUM_W-1:0]          num_reg;
    logic [DEN_W-1:0]          den_reg;
    logic [DEN_W:0]            rem_reg;
    logic [ALPHA_W-1:0]        quot_reg;
    logic [ALPHA_W-1:0]        alpha_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  a_reg;
    logic [P_W-1:0]            p_reg;
    result_t                   result_reg;

    // Item decode.
    logic [DT_W-1:0]           dt_in;
    logic [ANGLE_BITS-1:0]     yaw_c;
    logic signed [RATE_W-1:0]  z_c;
    logic [DEN_W-1:0]          den_in;

    always_comb
    begin
        if (item.step_time_us == 20'd0 || item.step_time_us > DT_MAX_US)
            dt_in = DT_DEFAULT_US[DT_W-1:0];
        else
            dt_in = item.step_time_us[DT_W-1:0];
        yaw_c = negate_reg ? (16'd0 - item.yaw_in) : item.yaw_in;
        if (!negate_reg)
            z_c = item.rate_z;
        else if (item.rate_z == 16'sh8000)
            z_c = 16'sh7fff;
        else
            z_c = -item.rate_z;
        den_in = {1'b0, tau_reg} + {2'b0, dt_in};
    end

    // Divider step.
    logic [DEN_W:0] trial;
    logic           ge;
    assign trial = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    // Shared multiplier operands.
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [33:0]        diff;
    logic signed [31:0]        f_sel;
    logic [GAIN_W-1:0]         gain_c;
    logic [FUSED_W-1:0]        err;
    logic signed [PROD_W-1:0]  rnd16;
    logic signed [PROD_W-1:0]  int_sum;
    logic signed [PROD_W-1:0]  int_inc;

    always_comb
    begin
        f_sel  = filt_reg[cmd.idx];
        diff   = $signed({raw_reg[cmd.idx][RATE_W-1], raw_reg[cmd.idx], 16'b0})
                 - $signed({{2{f_sel[31]}}, f_sel});
        gain_c = (gain_reg > GAIN_ONE) ? GAIN_ONE : gain_reg;
        err    = {sensor_reg, 8'b0} - fused_reg;
        mul_a  = '0;
        mul_b  = '0;
        case (cmd.op)
            OP_FMUL:
            begin
                mul_a = MUL_A_W'(diff);
                mul_b = $signed({3'b0, alpha_reg});
            end
            OP_PMUL:
            begin
                mul_a = $signed({21'b0, dt_reg});
                mul_b = $signed(INV_PI_MEGA);
            end
            OP_HIMUL:
            begin
                // The upper half of the filtered z rate is its signed floor.
                mul_a = $signed({2'b0, prod_reg[P_W-1:0]});
                mul_b = MUL_B_W'($signed(filt_reg[2][31:16]));
            end
            OP_LOMUL:
            begin
                mul_a = $signed({2'b0, p_reg});
                mul_b = $signed({4'b0, filt_reg[2][15:0]});
            end
            OP_CMUL:
            begin
                mul_a = MUL_A_W'($signed(err));
                mul_b = $signed({3'b0, gain_c});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        rnd16   = (prod_reg + PROD_W'(32768)) >>> 16;
        int_sum = a_reg + $signed((prod_reg + (PROD_W'(1) << (INT_SHIFT - 1))) >> 16);
        int_inc = int_sum >>> (INT_SHIFT - 16);
    end

    function automatic logic [RATE_W-1:0] round_sat(input logic signed [31:0] f);
        logic signed [32:0] r;
        logic signed [16:0] s;
        r = {f[31], f} + 33'sd32768;
        s = r[32:16];
        if (s[16] != s[15])
            round_sat = s[16] ? 16'h8000 : 16'h7fff;
        else
            round_sat = s[15:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            negate_reg       <= 1'b0;
            tau_reg          <= TAU_RESET;
            gain_reg         <= GAIN_RESET;
            zero_pending_reg <= 1'b1;
            zeroed_reg       <= 1'b0;
            has_orient_reg   <= 1'b0;
            has_rate_reg     <= 1'b0;
            offset_reg       <= '0;
            sensor_reg       <= '0;
            roll_reg         <= '0;
            pitch_reg        <= '0;
            fused_reg        <= '0;
            for (int i = 0; i < 3; i++)
            begin
                raw_reg[i]  <= '0;
                filt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_YAW_NEGATE: negate_reg <= cfg_data[0];
                    REG_TAU:        tau_reg    <= cfg_data[TAU_W-1:0];
                    REG_GAIN:       gain_reg   <= cfg_data[GAIN_W-1:0];
                    default:        ;
                endcase
            end
            case (cmd.op)
                OP_LOAD:
                begin
                    if (item.action)
                    begin
                        offset_reg       <= '0;
                        sensor_reg       <= '0;
                        fused_reg        <= '0;
                        zero_pending_reg <= 1'b1;
                        zeroed_reg       <= 1'b0;
                    end
                    else
                    begin
                        if (item.orient_valid)
                        begin
                            roll_reg       <= item.roll_in;
                            pitch_reg      <= item.pitch_in;
                            has_orient_reg <= 1'b1;
                            if (zero_pending_reg)
                            begin
                                offset_reg       <= yaw_c;
                                fused_reg        <= '0;
                                zeroed_reg       <= 1'b1;
                                zero_pending_reg <= 1'b0;
                                sensor_reg       <= '0;
                            end
                            else
                                sensor_reg <= yaw_c - offset_reg;
                        end
                        if (item.gyro_valid)
                        begin
                            raw_reg[0]   <= item.rate_x;
                            raw_reg[1]   <= item.rate_y;
                            raw_reg[2]   <= z_c;
                            has_rate_reg <= 1'b1;
                        end
                    end
                end
                OP_FACC:
                    filt_reg[cmd.idx] <= filt_reg[cmd.idx] + rnd16[31:0];
                OP_INTADD:
                    fused_reg <= fused_reg + int_inc[FUSED_W-1:0];
                OP_CADD:
                    fused_reg <= fused_reg + rnd16[FUSED_W-1:0];
                default: ;
            endcase
        end
    end

    // Arithmetic and output registers; no reset needed.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                dt_reg   <= dt_in;
                num_reg  <= {dt_in, 16'b0} + {15'b0, den_in >> 1};
                den_reg  <= den_in;
                rem_reg  <= '0;
                quot_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                rem_reg  <= ge ? (trial - {1'b0, den_reg}) : trial;
                num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
                quot_reg <= {quot_reg[ALPHA_W-2:0], ge};
            end
            OP_ALPHA:
                alpha_reg <= (tau_reg == '0) ? GAIN_ONE : quot_reg;
            OP_HIMUL:
                p_reg <= prod_reg[P_W-1:0];
            OP_LOMUL:
                a_reg <= prod_reg;
            OP_EMIT:
            begin
                result_reg.yaw_estimate    <= 16'((fused_reg + FUSED_W'(128)) >> 8);
                result_reg.yaw_sensor      <= sensor_reg;
                result_reg.roll_out        <= roll_reg;
                result_reg.pitch_out       <= pitch_reg;
                result_reg.filtered_rate_x <= round_sat(filt_reg[0]);
                result_reg.filtered_rate_y <= round_sat(filt_reg[1]);
                result_reg.filtered_rate_z <= round_sat(filt_reg[2]);
                result_reg.offset_latched  <= zeroed_reg;
                result_reg.has_orientation <= has_orient_reg;
                result_reg.has_rate        <= has_rate_reg;
            end
            default: ;
        endcase
        prod_reg <= mul_a * mul_b;
    end

    assign status.zeroed     = zeroed_reg;
    assign status.has_orient = has_orient_reg;
    assign result            = result_reg;

endmodule

// ===== rtl/yce_ctrl.sv =====
// Controller state machine: sequences the datapath and runs both handshakes.
// Depends on yce_pkg.
`timescale 1ns / 1ps

module yce_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output yce_pkg::dp_cmd_t    cmd,
    input  yce_pkg::dp_status_t status
);
    import yce_pkg::*;

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = (out_valid_reg && out_ready) ? 1'b0 : out_valid_reg;
        in_ready       = 1'b0;
        cmd.op         = OP_NONE;
        cmd.idx        = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cnt_next   = '0;
                state_next = status.zeroed ? S_DIV : S_EMIT;
            end
            S_DIV:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = S_ALPHA;
            end
            S_ALPHA:
            begin
                cmd.op     = OP_ALPHA;
                idx_next   = '0;
                state_next = S_FMUL;
            end
            S_FMUL:
            begin
                cmd.op     = OP_FMUL;
                state_next = S_FACC;
            end
            S_FACC:
            begin
                cmd.op = OP_FACC;
                if (idx_reg == 2'd2)
                    state_next = S_PMUL;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_FMUL;
                end
            end
            S_PMUL:
            begin
                cmd.op     = OP_PMUL;
                state_next = S_HIMUL;
            end
            S_HIMUL:
            begin
                cmd.op     = OP_HIMUL;
                state_next = S_LOMUL;
            end
            S_LOMUL:
            begin
                cmd.op     = OP_LOMUL;
                state_next = S_INTADD;
            end
            S_INTADD:
            begin
                cmd.op     = OP_INTADD;
                state_next = status.has_orient ? S_CMUL : S_EMIT;
            end
            S_CMUL:
            begin
                cmd.op     = OP_CMUL;
                state_next = S_CADD;
            end
            S_CADD:
            begin
                cmd.op     = OP_CADD;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/yaw_complementary_estimator.sv =====
// Top level of the yaw complementary estimator: controller plus datapath.
// Depends on yce_pkg, yce_item_if, yce_result_if, yce_ctrl and yce_datapath.
//
//   Channel   Dir  Handshake             Contents
//   in_ch     in   valid/ready           one sample item or zero-yaw request
//   out_ch    out  valid/ready           one result per request
//   cfg       in   cfg_write_en          yaw_negate, time constant, gain
//
// A request that leaves the yaw unzeroed passes through accept, check and result;
// its result becomes valid at the edge that leaves the result state.
// A zeroed sample passes through accept, check, the bit-serial divider that forms
// the filter coefficient, a step to latch it, the shared multiplier (three filter
// updates, the integration and, with orientation, the correction) and result.
// Reset is asynchronous and active low; it restores the register defaults and
// clears the estimate. A new request is taken while the previous result still
// waits; the block stalls only if a result is ready before the old one leaves.
`timescale 1ns / 1ps

module yaw_complementary_estimator (
    input  logic                           clk,
    input  logic                           rst_n,
    yce_item_if.sink                       in_ch,
    yce_result_if.source                   out_ch,
    input  logic                           cfg_write_en,
    input  logic [yce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [yce_pkg::CFG_DATA_W-1:0] cfg_data
);
    import yce_pkg::*;

    // Command and status between the controller and the datapath.
    dp_cmd_t    cmd;
    dp_status_t status;

    yce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // The datapath latches the item on the accepting edge and holds the
    // result in its output register until the request is taken.
    yce_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item         (in_ch.payload),
        .result       (out_ch.payload),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

endmodule

// ===== verif/yaw_complementary_estimator_tb.sv =====
// Self-checking testbench of the yaw complementary estimator.
// Depends on yce_pkg, yce_item_if, yce_result_if and the estimator RTL.
`timescale 1ns / 1ps

module yaw_complementary_estimator_tb;
    import yce_pkg::*;

    localparam int FW = 24;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    yce_item_if in_ch ();
    yce_result_if out_ch ();

    yaw_complementary_estimator dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Predictor state. It mirrors the block: configuration plus estimator state.
    logic        neg_cfg;
    logic [19:0] tau_cfg;
    logic [16:0] gain_cfg;
    logic        zero_pend;
    logic [15:0] offset_q;
    logic [15:0] sens_q;
    logic [FW-1:0] fused_q;
    logic [15:0] roll_q;
    logic [15:0] pitch_q;
    longint      raw_q [3];
    longint      filt_q [3];
    logic        zeroed_q;
    logic        orient_q;
    logic        rate_q;

    item_t   pending_requests [$];
    result_t expected_results [$];
    int      fail_count;
    int      send_idle_pct;
    int      recv_stall_pct;
    logic    hold_sender;
    logic    in_taken;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Floor division by a power of two; SystemVerilog >>> on longint is arithmetic.
    function automatic longint floor_shift(input longint x, input int s);
        return x >>> s;
    endfunction

    function automatic longint clamp_rate(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    task automatic reset_estimate();
        neg_cfg = 1'b0;
        tau_cfg = TAU_RESET;
        gain_cfg = GAIN_RESET;
        zero_pend = 1'b1;
        offset_q = '0;
        sens_q = '0;
        fused_q = '0;
        roll_q = '0;
        pitch_q = '0;
        for (int i = 0; i < 3; i++)
        begin
            raw_q[i] = 0;
            filt_q[i] = 0;
        end
        zeroed_q = 1'b0;
        orient_q = 1'b0;
        rate_q = 1'b0;
    endtask

    // Advance the estimator by one request and return the result it must produce.
    function automatic result_t estimate_step(input item_t it);
        result_t r;
        longint dt, alpha, d, f, fh, fl, p, a, b, inc, err, tau, g, rz;
        logic [15:0] y;
        logic [FW-1:0] diff;
        if (it.action)
        begin
            offset_q = '0;
            sens_q = '0;
            fused_q = '0;
            zero_pend = 1'b1;
            zeroed_q = 1'b0;
        end
        else
        begin
            dt = it.step_time_us;
            if (dt == 0 || dt > 500000)
                dt = 10000;
            if (it.orient_valid)
            begin
                y = it.yaw_in;
                if (neg_cfg)
                    y = -y;
                roll_q = it.roll_in;
                pitch_q = it.pitch_in;
                orient_q = 1'b1;
                if (zero_pend)
                begin
                    offset_q = y;
                    fused_q = '0;
                    zeroed_q = 1'b1;
                    zero_pend = 1'b0;
                end
                sens_q = y - offset_q;
            end
            if (it.gyro_valid)
            begin
                raw_q[0] = longint'(it.rate_x);
                raw_q[1] = longint'(it.rate_y);
                rz = longint'(it.rate_z);
                raw_q[2] = neg_cfg ? clamp_rate(-rz) : rz;
                rate_q = 1'b1;
            end
            if (zeroed_q)
            begin
                tau = tau_cfg;
                if (tau == 0)
                    alpha = 65536;
                else
                    alpha = ((dt << 16) + (tau + dt) / 2) / (tau + dt);
                for (int i = 0; i < 3; i++)
                begin
                    d = raw_q[i] * 65536 - filt_q[i];
                    filt_q[i] += floor_shift(alpha * d + 32768, 16);
                end
                f = filt_q[2];
                fh = floor_shift(f, 16);
                fl = f & 64'hFFFF;
                p = dt * 349985;
                a = fh * p;
                b = fl * p + (longint'(1) << (INT_SHIFT - 1));
                inc = floor_shift(a + (b >>> 16), INT_SHIFT - 16);
                fused_q = fused_q + inc[FW-1:0];
                if (orient_q)
                begin
                    g = (gain_cfg > GAIN_ONE) ? 65536 : longint'(gain_cfg);
                    diff = {sens_q, 8'h00} - fused_q;
                    err = longint'(signed'(diff));
                    inc = floor_shift(g * err + 32768, 16);
                    fused_q = fused_q + inc[FW-1:0];
                end
            end
        end
        r.yaw_estimate = 16'((fused_q + 24'd128) >> 8);
        r.yaw_sensor = sens_q;
        r.roll_out = roll_q;
        r.pitch_out = pitch_q;
        r.filtered_rate_x = 16'(clamp_rate(floor_shift(filt_q[0] + 32768, 16)));
        r.filtered_rate_y = 16'(clamp_rate(floor_shift(filt_q[1] + 32768, 16)));
        r.filtered_rate_z = 16'(clamp_rate(floor_shift(filt_q[2] + 32768, 16)));
        r.offset_latched = zeroed_q;
        r.has_orientation = orient_q;
        r.has_rate = rate_q;
        return r;
    endfunction

    // Driver: presents queued requests at the falling edge and keeps a request
    // unchanged until the rising edge that accepts it.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && !in_taken)
                in_ch.valid <= 1'b1;
            else if (pending_requests.size() != 0 && !hold_sender
                     && $urandom_range(99) >= send_idle_pct)
            begin
                in_ch.valid <= 1'b1;
                in_ch.payload <= pending_requests[0];
            end
            else
                in_ch.valid <= 1'b0;
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: checks every accepted result against the oldest prediction and
    // runs the predictor on every request accepted at this edge.
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, out_ch.payload);
                fail_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (out_ch.payload !== exp_r)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_r,
                             out_ch.payload);
                    fail_count++;
                end
            end
        end
        in_taken = rst_n && in_ch.valid && in_ch.ready;
        if (in_taken)
        begin
            expected_results.push_back(estimate_step(in_ch.payload));
            void'(pending_requests.pop_front());
        end
    end

    function automatic item_t random_request();
        item_t it;
        it = '0;
        it.action = ($urandom_range(99) < 4);
        it.orient_valid = ($urandom_range(99) < 60);
        it.gyro_valid = ($urandom_range(99) < 70);
        it.yaw_in = 16'($urandom);
        it.roll_in = 16'($urandom);
        it.pitch_in = 16'($urandom);
        it.rate_x = 16'($urandom);
        it.rate_y = 16'($urandom);
        it.rate_z = 16'($urandom);
        case ($urandom_range(5))
            0: it.step_time_us = 20'($urandom);
            1: it.step_time_us = 20'($urandom_range(500000));
            default: it.step_time_us = 20'($urandom_range(20000));
        endcase
        return it;
    endfunction

    // Configuration writes happen only while nothing is in flight.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            REG_YAW_NEGATE: neg_cfg = val[0];
            REG_TAU: tau_cfg = val;
            default: gain_cfg = val[16:0];
        endcase
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || expected_results.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic directed_items();
        item_t it;
        // Samples before any zeroing are only held; then the first orientation
        // latches the offset.
        it = '0;
        it.gyro_valid = 1'b1;
        it.rate_x = 16'sh7FFF;
        it.rate_y = 16'sh8000;
        it.rate_z = 16'sh8000;
        pending_requests.push_back(it);
        it.orient_valid = 1'b1;
        it.yaw_in = 16'sh8000;
        it.roll_in = 16'sh7FFF;
        it.pitch_in = 16'sh4000;
        it.step_time_us = 20'd0;
        pending_requests.push_back(it);
        it.orient_valid = 1'b0;
        it.step_time_us = 20'hFFFFF;
        pending_requests.push_back(it);
        it.step_time_us = 20'd500000;
        pending_requests.push_back(it);
        it.step_time_us = 20'd500001;
        pending_requests.push_back(it);
        it.step_time_us = 20'd1;
        pending_requests.push_back(it);
        it = '0;
        it.action = 1'b1;
        it.orient_valid = 1'b1;
        it.yaw_in = 16'sh1234;
        pending_requests.push_back(it);
        // After a zero request, rates keep coming without orientation.
        it = '0;
        it.gyro_valid = 1'b1;
        it.rate_z = 16'sh0400;
        it.step_time_us = 20'd10000;
        pending_requests.push_back(it);
        it.orient_valid = 1'b1;
        it.yaw_in = 16'sh7FFF;
        it.pitch_in = 16'shC000;
        pending_requests.push_back(it);
        it.yaw_in = 16'sh8001;
        it.pitch_in = 16'sh7FFF;
        pending_requests.push_back(it);
    endtask

    task automatic random_items(input int count);
        for (int i = 0; i < count; i++)
            pending_requests.push_back(random_request());
    endtask

    initial
    begin
        item_t zero_req;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = REG_YAW_NEGATE;
        cfg_data = '0;
        fail_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_sender = 1'b0;
        reset_estimate();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed pass at reset defaults, then with negation and extremes.
        directed_items();
        drain();
        write_reg(REG_YAW_NEGATE, 20'd1);
        write_reg(REG_TAU, 20'd0);
        write_reg(REG_GAIN, 20'd65536);
        directed_items();
        drain();

        // Random phases that cycle through four idling patterns, each with new settings.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            write_reg(REG_YAW_NEGATE, 20'($urandom_range(1)));
            case (ph)
                0: write_reg(REG_TAU, 20'd1000000);
                1: write_reg(REG_TAU, 20'hFFFFF);
                2: write_reg(REG_TAU, 20'd1);
                default: write_reg(REG_TAU, 20'($urandom_range(100000)));
            endcase
            case (ph)
                0: write_reg(REG_GAIN, 20'd0);
                1: write_reg(REG_GAIN, 20'h1FFFF);
                2: write_reg(REG_GAIN, 20'd65537);
                default: write_reg(REG_GAIN, 20'($urandom_range(65536)));
            endcase
            // Every phase starts from a zero request so that the filter runs.
            zero_req = '0;
            zero_req.action = 1'b1;
            pending_requests.push_back(zero_req);
            random_items(60);
            // Sender holds off until every expected result is back.
            while (pending_requests.size() != 0) @(negedge clk);
            hold_sender = 1'b1;
            while (expected_results.size() != 0) @(negedge clk);
            hold_sender = 1'b0;
            random_items(60);
            drain();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Slowest run: ~1000 requests, each up to a full zeroed sample of work plus long gaps.
    initial
    begin
        #8000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/yce_pkg.sv
rtl/yce_item_if.sv
rtl/yce_result_if.sv
rtl/yce_datapath.sv
rtl/yce_ctrl.sv
rtl/yaw_complementary_estimator.sv
verif/yaw_complementary_estimator_tb.sv
